// ===== rtl/voxel_cluster_vote_labeler_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef VOXEL_CLUSTER_VOTE_LABELER_DEFINES_SVH
`define VOXEL_CLUSTER_VOTE_LABELER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define VCVL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("vcvl check failed");

// A condition that must be followed by another one in the next cycle.
`define VCVL_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error("vcvl sequence check failed");

`endif

// ===== rtl/vcvl_pkg.sv =====
`default_nettype none
package vcvl_pkg;

    // Default sizing of the voxel stores and of the coordinate format.
    localparam int VCVL_MAX_VOXELS = 262144;
    localparam int VCVL_FRAC_BITS  = 4;

    // Field widths.
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 18;
    localparam int WORD_W  = 16;
    localparam int COUNT_W = 15;
    localparam int EXT_W   = 7;
    localparam int LIN_W   = 19;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 32;

    localparam logic [EXT_W-1:0]   EXT_MAX   = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'd32767;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_ROI   = 3'd1,
        CMD_POINT = 3'd2,
        CMD_END   = 3'd3,
        CMD_READ  = 3'd4
    } cmd_code_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SWEEP,
        S_DRAIN,
        S_PT1,
        S_PT2,
        S_PT3,
        S_PT4,
        S_PT5,
        S_ROI,
        S_READ,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic sw_rd;
        logic cnt_inc;
        logic pt_s1;
        logic pt_s2;
        logic pt_s3;
        logic pt_rd;
        logic pt_wr;
        logic roi_wr;
        logic rd_rd;
        logic res_ld;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic out_busy;
    } dp_stat_t;

    // Extents above the volume limit are saturated.
    function automatic logic [EXT_W-1:0] vcvl_extent(input logic [EXT_W-1:0] s);
        return (s > EXT_MAX) ? EXT_MAX : s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vcvl_ctrl.sv =====
`default_nettype none
module vcvl_ctrl
    import vcvl_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic [CMD_W-1:0] s_tuser,
    output logic                  s_tready,
    input  wire dp_stat_t         stat,
    output ctrl_cmd_t             cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: begin
                if (stat.cnt_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    case (cmd_code_t'(s_tuser))
                        CMD_START: state_next = S_CLEAR;
                        CMD_ROI:   state_next = S_ROI;
                        CMD_POINT: state_next = S_PT1;
                        CMD_END:   state_next = S_SWEEP;
                        CMD_READ:  state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (stat.cnt_last) state_next = S_DONE;
            end
            S_SWEEP: begin
                if (stat.cnt_last) state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_DONE;
            S_PT1:   state_next = S_PT2;
            S_PT2:   state_next = S_PT3;
            S_PT3:   state_next = S_PT4;
            S_PT4:   state_next = S_PT5;
            S_PT5:   state_next = S_DONE;
            S_ROI:   state_next = S_DONE;
            S_READ:  state_next = S_DONE;
            S_DONE: begin
                if (!stat.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_INIT;
        endcase
    end

    // Output logic.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_CLEAR: begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_SWEEP: begin
                cmd.sw_rd   = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_PT1:  cmd.pt_s1  = 1'b1;
            S_PT2:  cmd.pt_s2  = 1'b1;
            S_PT3:  cmd.pt_s3  = 1'b1;
            S_PT4:  cmd.pt_rd  = 1'b1;
            S_PT5:  cmd.pt_wr  = 1'b1;
            S_ROI:  cmd.roi_wr = 1'b1;
            S_READ: cmd.rd_rd  = 1'b1;
            S_DONE: cmd.res_ld = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/vcvl_dp.sv =====
`default_nettype none
module vcvl_dp
    import vcvl_pkg::*;
#(
    parameter int MAX_VOXELS = VCVL_MAX_VOXELS,
    parameter int FRAC_BITS  = VCVL_FRAC_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ctrl_cmd_t        cmd,
    output dp_stat_t              stat,
    input  wire logic [CMD_W-1:0] s_tuser,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic [EXT_W-1:0] size_x,
    input  wire logic [EXT_W-1:0] size_y,
    input  wire logic [EXT_W-1:0] size_z,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int AW   = $clog2(MAX_VOXELS);
    localparam int CW   = (AW + 1 > LIN_W) ? AW + 1 : LIN_W;
    localparam int HALF = (2 ** FRAC_BITS) / 2;
    localparam int VW   = WORD_W + COUNT_W;

    // Round to the nearest voxel: add one half, then floor by an arithmetic shift.
    function automatic logic signed [WORD_W:0] round_coord(input logic [WORD_W-1:0] c);
        logic signed [WORD_W:0] t;
        t = $signed({c[WORD_W-1], c}) + (WORD_W+1)'(HALF);
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic in_range(input logic signed [WORD_W:0] r,
                                      input logic [EXT_W-1:0] s);
        return !r[WORD_W] && (r[WORD_W-1:0] < {{(WORD_W-EXT_W){1'b0}}, s});
    endfunction

    // Voxel stores.
    logic                 roi_mem  [MAX_VOXELS];
    logic [COUNT_W-1:0]   cnt_mem  [MAX_VOXELS];
    logic [VW-1:0]        vote_mem [MAX_VOXELS];

    // Captured item.
    logic [CMD_W-1:0]  op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              roi_reg;
    logic [WORD_W-1:0] cx_reg, cy_reg, cz_reg, lab_reg;

    // Point pipeline.
    logic [5:0]        px_reg, py_reg, pz_reg, px_next, py_next, pz_next;
    logic              pok_reg, pok_next, lok_reg, lok_next;
    logic [11:0]       pt_reg, pt_next;
    logic [LIN_W-1:0]  lin_reg, lin_next;
    logic [12:0]       prod_y;
    logic [EXT_W-1:0]  sx_e, sy_e, sz_e;
    logic signed [WORD_W:0] rx, ry, rz;
    logic [CW-1:0]     lin_ext, idx_ext;
    logic              idx_ok, hit_reg;

    // Memory read data and sweep control.
    logic               roi_rd_reg;
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [VW-1:0]      vote_rd_reg;
    logic [AW-1:0]      cnt_reg, cnt_next, sw_addr_reg;
    logic               sw_wr_reg, win;

    // Memory port control.
    logic               cnt_we, cnt_re, vote_we, vote_re, roi_we;
    logic [AW-1:0]      cnt_wa, cnt_ra, vote_wa, vote_ra;
    logic [COUNT_W-1:0] cnt_wd;
    logic [VW-1:0]      vote_wd;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    assign sx_e = vcvl_extent(size_x);
    assign sy_e = vcvl_extent(size_y);
    assign sz_e = vcvl_extent(size_z);

    // Capture the item on its transfer.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            idx_reg <= s_tdata[17:0];
            roi_reg <= !s_tdata[33] && (s_tdata[33:18] != '0);
            cx_reg  <= s_tdata[49:34];
            cy_reg  <= s_tdata[65:50];
            cz_reg  <= s_tdata[81:66];
            lab_reg <= s_tdata[97:82];
        end
    end

    // Point stages: round and bound check, then y + sy*z, then x + sx*(...).
    always_comb begin
        rx       = round_coord(cx_reg);
        ry       = round_coord(cy_reg);
        rz       = round_coord(cz_reg);
        px_next  = rx[5:0];
        py_next  = ry[5:0];
        pz_next  = rz[5:0];
        pok_next = in_range(rx, sx_e) && in_range(ry, sy_e) && in_range(rz, sz_e);
        prod_y   = 13'(sy_e) * 13'(pz_reg);
        pt_next  = 12'(prod_y + 13'(py_reg));
        lin_next = LIN_W'(LIN_W'(sx_e) * LIN_W'(pt_reg) + LIN_W'(px_reg));
        lin_ext  = CW'(lin_reg);
        lok_next = pok_reg && (CW'(lin_next) < CW'(MAX_VOXELS));
        idx_ext  = CW'(idx_reg);
        idx_ok   = idx_ext < CW'(MAX_VOXELS);
    end

    always_ff @(posedge aclk) begin
        if (cmd.pt_s1) begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            pz_reg  <= pz_next;
            pok_reg <= pok_next;
        end
        if (cmd.pt_s2) begin
            pt_reg <= pt_next;
        end
        if (cmd.pt_s3) begin
            lin_reg <= lin_next;
            lok_reg <= lok_next;
        end
        if (cmd.pt_wr) begin
            hit_reg <= lok_reg && roi_rd_reg;
        end
    end

    // Sweep address counter and the write stage, which follows the read in the next cycle.
    assign stat.cnt_last = (cnt_reg == AW'(MAX_VOXELS - 1));
    assign cnt_next      = stat.cnt_last ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sw_wr_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) cnt_reg <= cnt_next;
            sw_wr_reg <= cmd.sw_rd;
        end
        sw_addr_reg <= cnt_reg;
    end

    assign win = cnt_rd_reg > vote_rd_reg[COUNT_W-1:0];

    // Memory port selection.
    always_comb begin
        cnt_we  = cmd.clr_wr || sw_wr_reg || (cmd.pt_wr && lok_reg && roi_rd_reg);
        cnt_wa  = cmd.clr_wr ? cnt_reg : (sw_wr_reg ? sw_addr_reg : lin_ext[AW-1:0]);
        cnt_wd  = (cmd.pt_wr && cnt_rd_reg != COUNT_MAX) ? cnt_rd_reg + 1'b1 :
                  (cmd.pt_wr ? cnt_rd_reg : '0);
        cnt_re  = cmd.sw_rd || cmd.pt_rd;
        cnt_ra  = cmd.sw_rd ? cnt_reg : lin_ext[AW-1:0];
        vote_we = cmd.clr_wr || (sw_wr_reg && win);
        vote_wa = cmd.clr_wr ? cnt_reg : sw_addr_reg;
        vote_wd = cmd.clr_wr ? '0 : {lab_reg, cnt_rd_reg};
        vote_re = cmd.sw_rd || cmd.rd_rd;
        vote_ra = cmd.sw_rd ? cnt_reg : idx_ext[AW-1:0];
        roi_we  = cmd.roi_wr && idx_ok;
    end

    // Count store.
    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) cnt_rd_reg <= cnt_mem[cnt_ra];
    end

    // Label and best-count store.
    always_ff @(posedge aclk) begin
        if (vote_we) vote_mem[vote_wa] <= vote_wd;
        if (vote_re) vote_rd_reg <= vote_mem[vote_ra];
    end

    // ROI mask store.
    always_ff @(posedge aclk) begin
        if (roi_we) roi_mem[idx_ext[AW-1:0]] <= roi_reg;
        if (cmd.pt_rd) roi_rd_reg <= roi_mem[lin_ext[AW-1:0]];
    end

    // Output register; the stored word keeps the label above the best count.
    always_comb begin
        m_tdata_next = '0;
        case (cmd_code_t'(op_reg))
            CMD_READ: begin
                if (idx_ok) begin
                    m_tdata_next = {1'b0, vote_rd_reg[COUNT_W-1:0],
                                    vote_rd_reg[VW-1:COUNT_W]};
                end
            end
            CMD_POINT: m_tdata_next = {hit_reg, {(OUT_W-1){1'b0}}};
            default:   m_tdata_next = '0;
        endcase
        m_tvalid_next = cmd.res_ld ? 1'b1 : (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (cmd.res_ld) m_tdata_reg <= m_tdata_next;
    end

    assign stat.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule
`default_nettype wire

// ===== rtl/voxel_cluster_vote_labeler.sv =====
// Processing: a path point steps through S_PT1 to S_PT5, an ROI write through S_ROI, a voxel read
// through S_READ, an unknown command straight to S_DONE; a start run clears and an end cluster sweeps every voxel.
// Throughput: one item at a time; the next transfer is taken in the cycle after the
// result is loaded, and a result is not loaded while the one before it is still stalled.
// Reset: synchronous, active low; afterwards a clearing pass over every voxel
// zeroes the count and vote stores while no item is taken. Extents reset to 64.
`default_nettype none
module voxel_cluster_vote_labeler
    import vcvl_pkg::*;
#(
    parameter int MAX_VOXELS = VCVL_MAX_VOXELS,
    parameter int FRAC_BITS  = VCVL_FRAC_BITS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // voxel_index[17:0], roi_value[33:18], coord_x[49:34], coord_y[65:50],
    // coord_z[81:66], cluster_label[97:82], zero fill above
    input  wire logic [IN_W-1:0]  s_tdata,
    // cmd[2:0]
    input  wire logic [CMD_W-1:0] s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // voxel_label[15:0], voxel_best[30:16], point_counted[31]
    output logic [OUT_W-1:0]      m_tdata,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    ctrl_cmd_t        cmd;
    dp_stat_t         stat;
    logic [EXT_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic             cfg_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= EXT_MAX;
            size_y_reg <= EXT_MAX;
            size_z_reg <= EXT_MAX;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SIZE_X: size_x_reg <= pwdata[EXT_W-1:0];
                REG_SIZE_Y: size_y_reg <= pwdata[EXT_W-1:0];
                REG_SIZE_Z: size_z_reg <= pwdata[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SIZE_X: prdata = 32'(size_x_reg);
            REG_SIZE_Y: prdata = 32'(size_y_reg);
            REG_SIZE_Z: prdata = 32'(size_z_reg);
            default:    prdata = '0;
        endcase
    end

    vcvl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vcvl_dp #(
        .MAX_VOXELS (MAX_VOXELS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .size_x   (size_x_reg),
        .size_y   (size_y_reg),
        .size_z   (size_z_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/vcvl_checker.sv =====
`default_nettype none
`include "voxel_cluster_vote_labeler_defines.svh"
module vcvl_checker
    import vcvl_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             pready
);

    // The configuration port never waits.
    `VCVL_ASSERT(a_pready, pready)
    // A stalled result stays offered and unchanged.
    `VCVL_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `VCVL_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
    // A counted point carries no label or best count.
    `VCVL_ASSERT(a_point_zero, !(m_tvalid && m_tdata[OUT_W-1]) || m_tdata[OUT_W-2:0] == '0)
    // Items are processed one at a time.
    `VCVL_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind voxel_cluster_vote_labeler vcvl_checker u_vcvl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
`default_nettype wire
